// ----- design/mcpd_pkg.sv -----
// Package for the multi-channel presence debouncer.
// Holds field widths, register indexes, reset values and the lane configuration type.
// No dependencies.
`timescale 1ns / 1ps

package mcpd_pkg;

  localparam int SLOTS_DEFAULT = 16;

  localparam int LEVEL_W      = 16;
  localparam int TIME_W       = 32;
  localparam int MAP_W        = 16;
  localparam int COUNT_W      = 5;
  localparam int IN_TDATA_W   = 48;
  localparam int OUT_FIELDS_W = MAP_W + COUNT_W + COUNT_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS         = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_MEANS_OCCUPIED = 1'd1;

  localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 32'd500;

  typedef struct packed {
    logic [TIME_W-1:0] debounce_ms;
    logic              high_means_occupied;
  } cfg_t;

endpackage

// ----- design/mcpd_lane.sv -----
// One debounce lane: confirmed and pending state and change time of a single slot.
// Depends on mcpd_pkg.
`timescale 1ns / 1ps

module mcpd_lane
  import mcpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              upd,
  input  logic              level,
  input  logic [TIME_W-1:0] now_ms,
  input  cfg_t              cfg,
  output logic              conf,
  output logic              changed
);

  logic              pend;
  logic [TIME_W-1:0] change_time;
  logic              cur;
  logic              arm;
  logic [TIME_W-1:0] elapsed;
  logic              hit;

  always_comb begin
    cur     = cfg.high_means_occupied ? level : ~level;
    arm     = (pend == conf);
    elapsed = arm ? '0 : (now_ms - change_time);
    hit     = (cur != conf) && (elapsed >= cfg.debounce_ms);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conf <= 1'b0;
      pend <= 1'b0;
    end else if (upd) begin
      pend <= cur;
      if (hit) begin
        conf <= cur;
      end
    end
  end

  // A new pending change starts its timer at the poll that first sees it.
  always_ff @(posedge clk) begin
    if (upd && (cur != conf) && arm) begin
      change_time <= now_ms;
    end
    if (upd) begin
      changed <= hit;
    end
  end

endmodule

// ----- design/mcpd_merge.sv -----
// Merge stage: gathers the lanes' confirmed states into the map, counts and change flag.
// Depends on mcpd_pkg.
`timescale 1ns / 1ps

module mcpd_merge
  import mcpd_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               load,
  input  logic [SLOTS-1:0]   conf,
  input  logic [SLOTS-1:0]   changed,
  output logic               out_valid,
  output logic [MAP_W-1:0]   occupied_map,
  output logic [COUNT_W-1:0] occupied_count,
  output logic [COUNT_W-1:0] free_count,
  output logic               any_change
);

  localparam int CNT_W = $clog2(SLOTS + 1);

  logic [CNT_W-1:0] cnt;
  logic [MAP_W-1:0] map;

  always_comb begin
    cnt = '0;
    for (int i = 0; i < SLOTS; i++) begin
      cnt = cnt + CNT_W'(conf[i]);
    end
  end

  for (genvar i = 0; i < MAP_W; i++) begin : g_map
    if (i < SLOTS) begin : g_on
      assign map[i] = conf[i];
    end else begin : g_off
      assign map[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (en && load) begin
      occupied_map   <= map;
      occupied_count <= COUNT_W'(cnt);
      free_count     <= COUNT_W'(COUNT_W'(SLOTS) - COUNT_W'(cnt));
      any_change     <= |changed;
    end
  end

endmodule

// ----- design/multi_channel_presence_debouncer.sv -----
// Multi-channel presence debouncer, top level: one lane per slot and a merge stage.
// Pipeline: accepted polls update the lanes; the merge stage registers the result.
// Throughput: one poll per cycle while m_tready does not stall the output.
// Reset (synchronous): all slots free, no pending changes, debounce_ms 500,
// high_means_occupied 0, no result held. Depends on mcpd_pkg, mcpd_lane, mcpd_merge.
`timescale 1ns / 1ps

module multi_channel_presence_debouncer
  import mcpd_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // raw_levels [15:0], now_ms [47:16]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // occupied_map [15:0], occupied_count [20:16], free_count [25:21],
  // any_change [26], zero [31:27]
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  cfg_t              cfg;
  logic              v1;
  logic              en;
  logic              acc;
  logic [SLOTS-1:0]  conf;
  logic [SLOTS-1:0]  changed;
  logic [LEVEL_W-1:0] raw_levels;
  logic [TIME_W-1:0] now_ms;
  logic [MAP_W-1:0]  occupied_map;
  logic [COUNT_W-1:0] occupied_count;
  logic [COUNT_W-1:0] free_count;
  logic              any_change;

  assign raw_levels = s_tdata[LEVEL_W-1:0];
  assign now_ms     = s_tdata[LEVEL_W +: TIME_W];

  assign en       = !m_tvalid || m_tready;
  assign s_tready = !v1 || en;
  assign acc      = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms         <= DEBOUNCE_RESET;
      cfg.high_means_occupied <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE_MS:         cfg.debounce_ms <= cfg_data[TIME_W-1:0];
        REG_HIGH_MEANS_OCCUPIED: cfg.high_means_occupied <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (acc) begin
      v1 <= 1'b1;
    end else if (en) begin
      v1 <= 1'b0;
    end
  end

  // Slots above the sixteen sensor bits always read a low level.
  for (genvar i = 0; i < SLOTS; i++) begin : g_lane
    logic lvl;
    if (i < LEVEL_W) begin : g_in
      assign lvl = raw_levels[i];
    end else begin : g_zero
      assign lvl = 1'b0;
    end

    mcpd_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .upd     (acc),
      .level   (lvl),
      .now_ms  (now_ms),
      .cfg     (cfg),
      .conf    (conf[i]),
      .changed (changed[i])
    );
  end

  mcpd_merge #(
    .SLOTS(SLOTS)
  ) u_merge (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .load           (v1),
    .conf           (conf),
    .changed        (changed),
    .out_valid      (m_tvalid),
    .occupied_map   (occupied_map),
    .occupied_count (occupied_count),
    .free_count     (free_count),
    .any_change     (any_change)
  );

  assign m_tdata = {{OUT_PAD_W{1'b0}}, any_change, free_count, occupied_count, occupied_map};

endmodule

// ----- design/mcpd_checker.sv -----
// Port-level checker for the presence debouncer, bound to the top level.
// Depends on mcpd_pkg and multi_channel_presence_debouncer.
`timescale 1ns / 1ps

module mcpd_checker
  import mcpd_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  logic [MAP_W-1:0]   occ_map;
  logic [COUNT_W-1:0] occ_cnt;
  logic [COUNT_W-1:0] free_cnt;

  assign occ_map  = m_tdata[MAP_W-1:0];
  assign occ_cnt  = m_tdata[MAP_W +: COUNT_W];
  assign free_cnt = m_tdata[MAP_W+COUNT_W +: COUNT_W];

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or was dropped");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
    else $error("result missing two cycles after input transfer");

  a_counts_sum: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> COUNT_W'(occ_cnt + free_cnt) == COUNT_W'(SLOTS))
    else $error("occupied and free counts do not add up to the slot count");

  a_count_map: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (SLOTS <= MAP_W) |-> $countones(occ_map) == 32'(occ_cnt))
    else $error("occupied count disagrees with the occupancy map");

endmodule

bind multi_channel_presence_debouncer mcpd_checker #(
  .SLOTS(SLOTS)
) u_mcpd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
